[rtl/core/factorial_prime_exponents_defines.svh]
// Assertion macros for the factorial prime exponent block checks.
`ifndef FACTORIAL_PRIME_EXPONENTS_DEFINES_SVH
`define FACTORIAL_PRIME_EXPONENTS_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FPE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpe check failed: same-cycle rule");

// Check cons in the cycle after ante.
`define FPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpe check failed: next-cycle rule");

`endif

[rtl/core/fpe_pkg.sv]
// Shared constants, prime table and divider types for the factorial prime exponent block.
`default_nettype none

package fpe_pkg;

    localparam int MAX_N      = 100;
    localparam int HARD_LIMIT = 100;
    localparam int NUM_PRIMES = 25;

    localparam int N_W   = 8;
    localparam int P_W   = 7;
    localparam int E_W   = 7;
    localparam int IDX_W = $clog2(NUM_PRIMES);
    localparam int CNT_W = $clog2(P_W);

    typedef struct packed {
        logic           start;
        logic [P_W-1:0] dividend;
        logic [P_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [P_W-1:0] prime_at(input logic [IDX_W-1:0] idx);
        logic [P_W-1:0] p;
        case (idx)
            5'd0:    p = 7'd2;
            5'd1:    p = 7'd3;
            5'd2:    p = 7'd5;
            5'd3:    p = 7'd7;
            5'd4:    p = 7'd11;
            5'd5:    p = 7'd13;
            5'd6:    p = 7'd17;
            5'd7:    p = 7'd19;
            5'd8:    p = 7'd23;
            5'd9:    p = 7'd29;
            5'd10:   p = 7'd31;
            5'd11:   p = 7'd37;
            5'd12:   p = 7'd41;
            5'd13:   p = 7'd43;
            5'd14:   p = 7'd47;
            5'd15:   p = 7'd53;
            5'd16:   p = 7'd59;
            5'd17:   p = 7'd61;
            5'd18:   p = 7'd67;
            5'd19:   p = 7'd71;
            5'd20:   p = 7'd73;
            5'd21:   p = 7'd79;
            5'd22:   p = 7'd83;
            5'd23:   p = 7'd89;
            5'd24:   p = 7'd97;
            default: p = '1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fpe_if.sv]
// Valid/ready channel interfaces for the number input and the factor results.
`default_nettype none

interface fpe_item_if
    import fpe_pkg::*;
    ;
    logic           valid;
    logic           ready;
    logic [N_W-1:0] n;

    modport source (output valid, output n, input ready);
    modport sink   (input valid, input n, output ready);
endinterface

interface fpe_result_if
    import fpe_pkg::*;
    ;
    logic           valid;
    logic           ready;
    logic [P_W-1:0] prime;
    logic [E_W-1:0] exponent;
    logic           invalid;
    logic           last;

    modport source (output valid, output prime, output exponent, output invalid,
                    output last, input ready);
    modport sink   (input valid, input prime, input exponent, input invalid,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/core/fpe_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module fpe_div
    import fpe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output      div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]   rem_reg, rem_next;
    logic [P_W-1:0]   quo_reg, quo_next;
    logic [P_W-1:0]   den_reg, den_next;

    logic [P_W:0]     trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[P_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? P_W'(trial - {1'b0, den_reg}) : P_W'(trial);
            quo_next = {quo_reg[P_W-2:0], fits};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(P_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/factorial_prime_exponents.sv]
// Factorization of n factorial: one transfer per prime up to n with its exponent, Legendre's
// formula (sum of n / p^k) evaluated by repeated division of n by p. A number n is taken
// only when the block is idle; for a valid n (2 to 100) it then yields one result per prime
// p <= n in ascending order, the last one flagged, and an out-of-range n yields a single
// result flagged invalid and last. Each division is a test in S_CHECK that starts the
// shared bit-serial divider, the divider's quotient-bit steps and S_DIV taking the quotient.
// Each prime needs floor(log_p(n)) divisions plus a final test in S_CHECK and the result
// hand-off in S_OUT, which waits for the result side to be ready.
`default_nettype none

module factorial_prime_exponents
    import fpe_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fpe_item_if.sink    item,
    fpe_result_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [P_W-1:0]   q_reg, q_next;
    logic [E_W-1:0]   e_reg, e_next;
    logic [P_W-1:0]   prime_reg, prime_next;
    logic [E_W-1:0]   exp_reg, exp_next;
    logic             invalid_reg, invalid_next;
    logic             last_reg, last_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic             n_ok;
    logic [P_W-1:0]   cur_prime;
    logic             final_prime;

    assign n_ok = (item.n >= N_W'(2)) && (item.n <= N_W'(MAX_N))
               && (item.n <= N_W'(HARD_LIMIT));

    assign cur_prime   = prime_at(idx_reg);
    assign final_prime = (idx_reg == IDX_W'(NUM_PRIMES - 1))
                      || ({1'b0, prime_at(IDX_W'(idx_reg + 1'b1))} > n_reg);

    assign div_req.start    = (state_reg == S_CHECK) && (q_reg >= cur_prime);
    assign div_req.dividend = q_reg;
    assign div_req.divisor  = cur_prime;

    fpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        q_next       = q_reg;
        e_next       = e_reg;
        prime_next   = prime_reg;
        exp_next     = exp_reg;
        invalid_next = invalid_reg;
        last_next    = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    n_next   = item.n;
                    idx_next = '0;
                    q_next   = P_W'(item.n);
                    e_next   = '0;
                    if (n_ok)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        prime_next   = '0;
                        exp_next     = '0;
                        invalid_next = 1'b1;
                        last_next    = 1'b1;
                        state_next   = S_OUT;
                    end
                end
            end
            S_CHECK:
            begin
                if (q_reg >= cur_prime)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    prime_next   = cur_prime;
                    exp_next     = e_reg;
                    invalid_next = 1'b0;
                    last_next    = final_prime;
                    state_next   = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient;
                    e_next     = E_W'(e_reg + div_rsp.quotient);
                    state_next = S_CHECK;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(idx_reg + 1'b1);
                        q_next     = P_W'(n_reg);
                        e_next     = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        q_reg       <= q_next;
        e_reg       <= e_next;
        prime_reg   <= prime_next;
        exp_reg     <= exp_next;
        invalid_reg <= invalid_next;
        last_reg    <= last_next;
    end

    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = (state_reg == S_OUT);
    assign result.prime    = prime_reg;
    assign result.exponent = exp_reg;
    assign result.invalid  = invalid_reg;
    assign result.last     = last_reg;

endmodule

`default_nettype wire

[rtl/core/fpe_checker.sv]
// Port-level checks for the factorial prime exponent block, bound to the top level.
`default_nettype none
`include "factorial_prime_exponents_defines.svh"

module fpe_checker
    import fpe_pkg::*;
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           item_valid,
    input wire logic           item_ready,
    input wire logic           result_valid,
    input wire logic           result_ready,
    input wire logic [P_W-1:0] result_prime,
    input wire logic [E_W-1:0] result_exponent,
    input wire logic           result_invalid,
    input wire logic           result_last
);

    logic item_xfer;
    logic result_xfer;

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    `FPE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_prime) && $stable(result_exponent)
        && $stable(result_invalid) && $stable(result_last))
    `FPE_ASSERT_SAME(a_no_overlap, item_xfer, !result_valid)
    `FPE_ASSERT_NEXT(a_busy_after_take, item_xfer, !item_ready)
    `FPE_ASSERT_SAME(a_invalid_form, result_valid && result_invalid,
        result_last && (result_prime == '0) && (result_exponent == '0))
    `FPE_ASSERT_NEXT(a_idle_after_last, result_xfer && result_last, item_ready)

endmodule

bind factorial_prime_exponents fpe_checker u_fpe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_prime    (result.prime),
    .result_exponent (result.exponent),
    .result_invalid  (result.invalid),
    .result_last     (result.last)
);

`default_nettype wire
